/* src/ptd_pkg.sv */
// shared types and constants for the pcm timer dma controller
`timescale 1ns / 1ps
package ptd_pkg;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] port;
      logic [7:0]  write_data;
      logic [7:0]  dma_first;
      logic [7:0]  dma_second;
   } req_type;

   typedef struct packed {
      logic [7:0]         read_data;
      logic               irq_request;
      logic [1:0]         dma_bytes_taken;
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
   } rsp_type;

   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [16:0] CNT_SPENT = 17'h1FFFF;
   localparam logic [16:0] CNT_FULL  = 17'h10000;

   localparam logic [7:0] INT_SAMP   = 8'h04;
   localparam logic [7:0] INT_PCM    = 8'h08;
   localparam logic [7:0] PCM_MONO   = 8'h20;
   localparam logic [7:0] PCM_ENA    = 8'h40;
   localparam logic [7:0] SC2_16BIT  = 8'h04;
   localparam logic [7:0] SC2_MSBINV = 8'h10;
   localparam logic [7:0] FILT_MUTE  = 8'h20;

   localparam int NUM_PLAIN = 13;

endpackage

/* src/pcm_timer_dma_controller.sv */
// top level: pcm engine with three-channel interval timer and dma sample fetch
// response: a request's response is registered on acceptance and is valid in the next cycle
// throughput: one request per cycle; a new request is taken in the cycle the previous
// response leaves, and held off while a response waits under stall
// reset: synchronous active-high reset clears all timer, interrupt and sample state
`timescale 1ns / 1ps
module pcm_timer_dma_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ptd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ptd_pkg::rsp_type  rsp_data
);
   import ptd_pkg::*;

   logic [7:0]  irq_status_ff, irq_status_in;
   logic [7:0]  irq_enable_ff, irq_enable_in;
   logic [7:0]  pcm_control_ff, pcm_control_in;
   logic [7:0]  filter_control_ff, filter_control_in;
   logic [7:0]  last_command_ff, last_command_in;
   logic [7:0]  plain_ff [NUM_PLAIN];
   logic [7:0]  plain_in [NUM_PLAIN];
   logic        stereo_ff, stereo_in;
   logic [15:0] left_ff, left_in, right_ff, right_in;
   logic [16:0] count_ff [3];
   logic [16:0] count_in [3];
   logic [16:0] reload_ff [3];
   logic [16:0] reload_in [3];
   logic [2:0]  running_ff, running_in;
   logic [15:0] hold_ff [3];
   logic [15:0] hold_in [3];
   logic [1:0]  rbm_ff [3];
   logic [1:0]  rbm_in [3];
   logic [1:0]  wbm_ff [3];
   logic [1:0]  wbm_in [3];
   logic [2:0]  mode_ff [3];
   logic [2:0]  mode_in [3];
   logic [2:0]  refresh_ff, refresh_in;

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   function automatic logic [15:0] latch_of(input logic [16:0] c);
      latch_of = (c > CNT_FULL) ? 16'h0000 : c[15:0];
   endfunction

   function automatic logic [15:0] refresh_of(input logic [16:0] c);
      refresh_of = (c > CNT_FULL) ? 16'hFFFF : c[15:0];
   endfunction

   always_comb begin
      logic [1:0]  kind;
      logic [15:0] p;
      logic [7:0]  v;
      logic [7:0]  rd;
      logic [1:0]  taken;
      logic        pit_hit;
      logic [1:0]  sel;
      logic [2:0]  m;
      logic        wide;
      logic [15:0] s;
      logic [16:0] dec;
      logic [16:0] c1;
      kind = req_data.kind;
      p    = req_data.port;
      v    = req_data.write_data;
      rd   = 8'h00;
      taken = 2'd0;
      pit_hit = (p >= 16'h1388) && (p <= 16'h138B);
      sel  = p[1:0];
      m    = 3'd0;
      wide = (plain_ff[3] & SC2_16BIT) != 8'h00;
      s    = 16'h0000;
      dec  = wide ? 17'd2 : 17'd1;
      c1   = 17'd0;

      irq_status_in     = irq_status_ff;
      irq_enable_in     = irq_enable_ff;
      pcm_control_in    = pcm_control_ff;
      filter_control_in = filter_control_ff;
      last_command_in   = last_command_ff;
      plain_in          = plain_ff;
      stereo_in         = stereo_ff;
      left_in           = left_ff;
      right_in          = right_ff;
      count_in          = count_ff;
      reload_in         = reload_ff;
      running_in        = running_ff;
      hold_in           = hold_ff;
      rbm_in            = rbm_ff;
      wbm_in            = wbm_ff;
      mode_in           = mode_ff;
      refresh_in        = refresh_ff;

      case (kind)
         KIND_READ: begin
            if (pit_hit) begin
               if (sel == 2'd3) begin
                  rd = last_command_ff;
               end else begin
                  if (refresh_ff[sel]) begin
                     hold_in[sel] = refresh_of(count_ff[sel]);
                  end
                  case (rbm_ff[sel])
                     2'd0: begin
                        rd = hold_in[sel][15:8];
                        rbm_in[sel] = 2'd3;
                        refresh_in[sel] = 1'b1;
                     end
                     2'd1: begin
                        rd = hold_in[sel][7:0];
                        refresh_in[sel] = 1'b1;
                     end
                     2'd2: begin
                        rd = hold_in[sel][15:8];
                        refresh_in[sel] = 1'b1;
                     end
                     default: begin
                        rd = hold_in[sel][7:0];
                        rbm_in[sel] = 2'd0;
                        refresh_in[sel] = 1'b0;
                     end
                  endcase
               end
            end else begin
               case (p)
                  16'h0B88: rd = plain_ff[0];
                  16'h0B89: rd = irq_status_ff;
                  16'h0B8A: rd = filter_control_ff;
                  16'h0B8B: rd = (irq_enable_ff & ~8'hE0) | 8'h20;
                  16'h0F8A: rd = pcm_control_ff;
                  16'h2789: rd = 8'h01;
                  16'h7F89: rd = plain_ff[1] & ~8'h01;
                  16'h8388: rd = plain_ff[2];
                  16'h8389: rd = plain_ff[3];
                  16'h838B: rd = plain_ff[4];
                  16'h838C: rd = plain_ff[5];
                  16'hEF8B: rd = 8'h0C;
                  16'hF388: rd = plain_ff[6];
                  16'hF389: rd = plain_ff[7];
                  16'hF38B: rd = plain_ff[8];
                  16'hF38C: rd = plain_ff[9];
                  16'hF788: rd = plain_ff[10];
                  16'hF789: rd = plain_ff[11];
                  16'hFB8A: rd = plain_ff[12];
                  16'hFF88: rd = 8'h03;
                  16'hFF8B: rd = 8'h20 | 8'h10 | 8'h01;
                  default:  rd = 8'h00;
               endcase
            end
         end
         KIND_WRITE: begin
            if (pit_hit) begin
               if (sel == 2'd3) begin
                  if ((v & 8'hC0) == 8'hC0) begin
                     if (!v[5]) begin
                        for (int t = 0; t < 3; t++) begin
                           if (v[t+1]) hold_in[t] = latch_of(count_ff[t]);
                        end
                     end
                  end else begin
                     last_command_in = v;
                     if ((v & 8'h30) == 8'h00) begin
                        hold_in[v[7:6]]    = latch_of(count_ff[v[7:6]]);
                        last_command_in    = v | 8'h30;
                        refresh_in[v[7:6]] = 1'b0;
                        rbm_in[v[7:6]]     = 2'd3;
                     end else begin
                        m = v[3:1];
                        if (m > 3'd5) m = {1'b0, m[1:0]};
                        rbm_in[v[7:6]]     = v[5:4];
                        wbm_in[v[7:6]]     = v[5:4];
                        mode_in[v[7:6]]    = m;
                        refresh_in[v[7:6]] = 1'b1;
                     end
                  end
               end else begin
                  case (wbm_ff[sel])
                     2'd1: begin
                        reload_in[sel] = {9'd0, v};
                        count_in[sel] = {9'd0, v};
                        running_in[sel] = 1'b1;
                     end
                     2'd2: begin
                        reload_in[sel] = {1'b0, v, 8'h00};
                        count_in[sel] = {1'b0, v, 8'h00};
                        running_in[sel] = 1'b1;
                     end
                     2'd0: begin
                        reload_in[sel] = {1'b0, v, reload_ff[sel][7:0]};
                        count_in[sel] = {1'b0, v, reload_ff[sel][7:0]};
                        wbm_in[sel] = 2'd3;
                        running_in[sel] = 1'b1;
                     end
                     default: begin
                        reload_in[sel] = {1'b0, reload_ff[sel][15:8], v};
                        wbm_in[sel] = 2'd0;
                     end
                  endcase
                  if (reload_in[sel] == 17'd0) begin
                     reload_in[sel] = CNT_FULL;
                     count_in[sel] = CNT_FULL;
                  end
               end
            end else begin
               case (p)
                  16'h0B88: plain_in[0] = v;
                  16'h0B89: irq_status_in = irq_status_ff & ~v;
                  16'h0B8A: filter_control_in = v;
                  16'h0B8B: irq_enable_in = v;
                  16'h0F8A: pcm_control_in = v;
                  16'h7F89: plain_in[1] = v;
                  16'h8388: plain_in[2] = v;
                  16'h8389: plain_in[3] = v;
                  16'h838A: plain_in[4] = v;
                  16'h838B: plain_in[5] = v;
                  16'hF388: plain_in[6] = v;
                  16'hF389: plain_in[7] = v;
                  16'hF38A: plain_in[8] = v;
                  16'hF38B: plain_in[9] = v;
                  16'hF788: plain_in[10] = v;
                  16'hF789: plain_in[11] = v;
                  16'hFB8A: plain_in[12] = v;
                  default: ;
               endcase
            end
         end
         KIND_TICK: begin
            if (running_ff[0]) begin
               if (count_ff[0] > 17'd1) begin
                  count_in[0] = count_ff[0] - 17'd1;
               end else begin
                  // channel 0 expiry: reload or stop, sample interrupt, and dma fetch while channel 1 runs
                  if (mode_ff[0][1]) begin
                     count_in[0] = (reload_ff[0] != 17'd0) ? reload_ff[0] : CNT_FULL;
                  end else begin
                     count_in[0] = CNT_SPENT;
                     running_in[0] = 1'b0;
                  end
                  irq_status_in = irq_status_ff | INT_SAMP;
                  if (running_ff[1]) begin
                     if ((pcm_control_ff & PCM_ENA) != 8'h00) begin
                        if (wide) begin
                           s = {req_data.dma_first, req_data.dma_second};
                           taken = 2'd2;
                        end else begin
                           s = {req_data.dma_first ^ 8'h80, 8'h00};
                           taken = 2'd1;
                        end
                        if ((plain_ff[3] & SC2_MSBINV) != 8'h00) s = s ^ 16'h8000;
                        if ((pcm_control_ff & PCM_MONO) != 8'h00) begin
                           left_in = s;
                           right_in = s;
                        end else begin
                           if (stereo_ff) right_in = s;
                           else left_in = s;
                           stereo_in = ~stereo_ff;
                        end
                     end
                     if (count_ff[1] > CNT_FULL) begin
                        count_in[1] = count_ff[1];
                     end else if (count_ff[1] < dec) begin
                        count_in[1] = CNT_SPENT;
                     end else begin
                        c1 = count_ff[1] - dec;
                        count_in[1] = c1;
                        if (c1 == 17'd0) begin
                           if (mode_ff[1][1]) begin
                              count_in[1] = (reload_ff[1] != 17'd0) ? reload_ff[1]
                                                                    : CNT_FULL;
                           end else begin
                              count_in[1] = CNT_SPENT;
                              running_in[1] = 1'b0;
                           end
                           irq_status_in = irq_status_in | INT_PCM;
                        end
                     end
                  end
               end
            end
         end
         default: ;
      endcase

      rsp_in.read_data       = rd;
      rsp_in.irq_request     = (irq_status_in & irq_enable_in & (INT_SAMP | INT_PCM)) != 8'h00;
      rsp_in.dma_bytes_taken = taken;
      rsp_in.left_out  = ((filter_control_in & FILT_MUTE) != 8'h00) ? left_in : 16'sd0;
      rsp_in.right_out = ((filter_control_in & FILT_MUTE) != 8'h00) ? right_in : 16'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_status_ff     <= '0;
         irq_enable_ff     <= '0;
         pcm_control_ff    <= '0;
         filter_control_ff <= '0;
         last_command_ff   <= '0;
         stereo_ff         <= 1'b0;
         left_ff           <= '0;
         right_ff          <= '0;
         running_ff        <= '0;
         refresh_ff        <= '0;
         rsp_valid_ff      <= 1'b0;
         for (int i = 0; i < NUM_PLAIN; i++) plain_ff[i] <= '0;
         for (int t = 0; t < 3; t++) begin
            count_ff[t]  <= '0;
            reload_ff[t] <= '0;
            hold_ff[t]   <= '0;
            rbm_ff[t]    <= '0;
            wbm_ff[t]    <= '0;
            mode_ff[t]   <= '0;
         end
      end else begin
         if (accept) begin
            irq_status_ff     <= irq_status_in;
            irq_enable_ff     <= irq_enable_in;
            pcm_control_ff    <= pcm_control_in;
            filter_control_ff <= filter_control_in;
            last_command_ff   <= last_command_in;
            plain_ff          <= plain_in;
            stereo_ff         <= stereo_in;
            left_ff           <= left_in;
            right_ff          <= right_in;
            count_ff          <= count_in;
            reload_ff         <= reload_in;
            running_ff        <= running_in;
            hold_ff           <= hold_in;
            rbm_ff            <= rbm_in;
            wbm_ff            <= wbm_in;
            mode_ff           <= mode_in;
            refresh_ff        <= refresh_in;
            rsp_valid_ff      <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no response");
   a_nontick_no_dma: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind != KIND_TICK |=> rsp_data.dma_bytes_taken == 2'd0)
      else $error("dma bytes taken outside a tick");
   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind != KIND_READ |=> rsp_data.read_data == 8'h00)
      else $error("read data nonzero outside a read");
   a_spent_stopped: assert property (@(posedge clock) disable iff (reset)
      count_ff[0] == CNT_SPENT |-> !running_ff[0])
      else $error("channel 0 spent but still running");
`endif

endmodule

/* sim/tb_pcm_timer_dma_controller.sv */
// testbench for the pcm timer dma controller: random port traffic and timer ticks
`timescale 1ns / 1ps
module tb_pcm_timer_dma_controller;
   import ptd_pkg::*;

   class pcm_scoreboard;
      logic [7:0]  irq_status, irq_enable, pcm_control, filter_control, last_command;
      logic [7:0]  plain_regs [NUM_PLAIN];
      logic        stereo_toggle;
      logic [15:0] left_sample, right_sample;
      logic [16:0] count_value [3];
      logic [16:0] reload_value [3];
      logic        count_running [3];
      logic [15:0] read_holding [3];
      logic [1:0]  read_byte_mode [3];
      logic [1:0]  write_byte_mode [3];
      logic [2:0]  counting_mode [3];
      logic        refresh_on_read [3];
      rsp_type     pending_rsp [$];
      int          mismatches;

      function void clear_state();
         irq_status = 0; irq_enable = 0; pcm_control = 0; filter_control = 0;
         last_command = 0; stereo_toggle = 0; left_sample = 0; right_sample = 0;
         mismatches = 0;
         foreach (plain_regs[i]) plain_regs[i] = 0;
         for (int t = 0; t < 3; t++) begin
            count_value[t] = 0; reload_value[t] = 0; count_running[t] = 0;
            read_holding[t] = 0; read_byte_mode[t] = 0; write_byte_mode[t] = 0;
            counting_mode[t] = 0; refresh_on_read[t] = 0;
         end
      endfunction

      function logic [15:0] latched_count(int t);
         return (count_value[t] > CNT_FULL) ? 16'h0 : count_value[t][15:0];
      endfunction

      function void expire_channel(int t);
         if (counting_mode[t][1]) begin
            count_value[t] = (reload_value[t] != 0) ? reload_value[t] : CNT_FULL;
         end else begin
            count_value[t] = CNT_SPENT;
            count_running[t] = 0;
         end
      endfunction

      function void timer_write(int sel, logic [7:0] v);
         logic [2:0] m;
         int t;
         if (sel == 3) begin
            if (v[7:6] == 2'b11) begin
               if (!v[5])
                  for (int c = 0; c < 3; c++)
                     if (v[c+1]) read_holding[c] = latched_count(c);
               return;
            end
            t = v[7:6];
            last_command = v;
            if (v[5:4] == 0) begin
               read_holding[t] = latched_count(t);
               last_command = v | 8'h30;
               refresh_on_read[t] = 0;
               read_byte_mode[t] = 3;
            end else begin
               m = v[3:1];
               read_byte_mode[t] = v[5:4];
               write_byte_mode[t] = v[5:4];
               if (m > 5) m = m & 3'd3;
               counting_mode[t] = m;
               refresh_on_read[t] = 1;
            end
            return;
         end
         t = sel;
         case (write_byte_mode[t])
            1: begin
               reload_value[t] = {9'd0, v};
               count_value[t] = reload_value[t];
               count_running[t] = 1;
            end
            2: begin
               reload_value[t] = {1'b0, v, 8'd0};
               count_value[t] = reload_value[t];
               count_running[t] = 1;
            end
            0: begin
               reload_value[t] = {1'b0, v, reload_value[t][7:0]};
               count_value[t] = reload_value[t];
               write_byte_mode[t] = 3;
               count_running[t] = 1;
            end
            default: begin
               reload_value[t] = {1'b0, reload_value[t][15:8], v};
               write_byte_mode[t] = 0;
            end
         endcase
         if (reload_value[t] == 0) begin
            reload_value[t] = CNT_FULL;
            count_value[t] = CNT_FULL;
         end
      endfunction

      function logic [7:0] timer_read(int sel);
         logic [7:0] r;
         int t;
         if (sel == 3) return last_command;
         t = sel;
         if (refresh_on_read[t]) begin
            refresh_on_read[t] = 0;
            read_holding[t] = (count_value[t] > CNT_FULL) ? 16'hFFFF : count_value[t][15:0];
         end
         case (read_byte_mode[t])
            0: begin
               r = read_holding[t][15:8]; read_byte_mode[t] = 3; refresh_on_read[t] = 1;
            end
            1: begin r = read_holding[t][7:0]; refresh_on_read[t] = 1; end
            2: begin r = read_holding[t][15:8]; refresh_on_read[t] = 1; end
            default: begin r = read_holding[t][7:0]; read_byte_mode[t] = 0; end
         endcase
         return r;
      endfunction

      function logic [7:0] port_read(logic [15:0] p);
         if (p >= 16'h1388 && p <= 16'h138B) return timer_read(p[1:0]);
         case (p)
            16'h0B88: return plain_regs[0];
            16'h0B89: return irq_status;
            16'h0B8A: return filter_control;
            16'h0B8B: return (irq_enable & ~8'hE0) | 8'h20;
            16'h0F8A: return pcm_control;
            16'h2789: return 8'd1;
            16'h7F89: return plain_regs[1] & ~8'h01;
            16'h8388: return plain_regs[2];
            16'h8389: return plain_regs[3];
            16'h838B: return plain_regs[4];
            16'h838C: return plain_regs[5];
            16'hEF8B: return 8'h0C;
            16'hF388: return plain_regs[6];
            16'hF389: return plain_regs[7];
            16'hF38B: return plain_regs[8];
            16'hF38C: return plain_regs[9];
            16'hF788: return plain_regs[10];
            16'hF789: return plain_regs[11];
            16'hFB8A: return plain_regs[12];
            16'hFF88: return 8'd3;
            16'hFF8B: return 8'h31;
            default:  return 8'd0;
         endcase
      endfunction

      function void port_write(logic [15:0] p, logic [7:0] v);
         if (p >= 16'h1388 && p <= 16'h138B) begin
            timer_write(p[1:0], v);
            return;
         end
         case (p)
            16'h0B88: plain_regs[0] = v;
            16'h0B89: irq_status = irq_status & ~v;
            16'h0B8A: filter_control = v;
            16'h0B8B: irq_enable = v;
            16'h0F8A: pcm_control = v;
            16'h7F89: plain_regs[1] = v;
            16'h8388: plain_regs[2] = v;
            16'h8389: plain_regs[3] = v;
            16'h838A: plain_regs[4] = v;
            16'h838B: plain_regs[5] = v;
            16'hF388: plain_regs[6] = v;
            16'hF389: plain_regs[7] = v;
            16'hF38A: plain_regs[8] = v;
            16'hF38B: plain_regs[9] = v;
            16'hF788: plain_regs[10] = v;
            16'hF789: plain_regs[11] = v;
            16'hFB8A: plain_regs[12] = v;
            default: ;
         endcase
      endfunction

      function logic [1:0] fetch_sample(logic [7:0] b1, logic [7:0] b2);
         logic        wide;
         logic [15:0] s;
         logic [1:0]  taken;
         logic [16:0] dec;
         taken = 0;
         wide = (plain_regs[3] & SC2_16BIT) != 0;
         expire_channel(0);
         irq_status = irq_status | INT_SAMP;
         if (!count_running[1]) return 2'd0;
         if (pcm_control & PCM_ENA) begin
            if (wide) begin s = {b1, b2}; taken = 2; end
            else begin s = {b1 ^ 8'h80, 8'h00}; taken = 1; end
            if (plain_regs[3] & SC2_MSBINV) s = s ^ 16'h8000;
            if (pcm_control & PCM_MONO) begin
               left_sample = s; right_sample = s;
            end else begin
               if (stereo_toggle) right_sample = s; else left_sample = s;
               stereo_toggle = ~stereo_toggle;
            end
         end
         dec = wide ? 17'd2 : 17'd1;
         if (count_value[1] > CNT_FULL) begin
            // spent count stays below zero
         end else if (count_value[1] < dec) begin
            count_value[1] = CNT_SPENT;
         end else begin
            count_value[1] = count_value[1] - dec;
            if (count_value[1] == 0) begin
               expire_channel(1);
               irq_status = irq_status | INT_PCM;
            end
         end
         return taken;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         e = '0;
         if (r.kind == KIND_READ) begin
            e.read_data = port_read(r.port);
         end else if (r.kind == KIND_WRITE) begin
            port_write(r.port, r.write_data);
         end else if (r.kind == KIND_TICK) begin
            if (count_running[0]) begin
               if (count_value[0] > 1) count_value[0] = count_value[0] - 17'd1;
               else e.dma_bytes_taken = fetch_sample(r.dma_first, r.dma_second);
            end
         end
         e.irq_request = (irq_status & irq_enable & (INT_SAMP | INT_PCM)) != 0;
         if (filter_control & FILT_MUTE) begin
            e.left_out = left_sample;
            e.right_out = right_sample;
         end
         pending_rsp.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", a);
            return;
         end
         e = pending_rsp.pop_front();
         if (a.read_data !== e.read_data || a.irq_request !== e.irq_request ||
             a.dma_bytes_taken !== e.dma_bytes_taken || a.left_out !== e.left_out ||
             a.right_out !== e.right_out) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: rd %h/%h irq %b/%b taken %0d/%0d l %h/%h r %h/%h",
                  e.read_data, a.read_data, e.irq_request, a.irq_request,
                  e.dma_bytes_taken, a.dma_bytes_taken, e.left_out, a.left_out,
                  e.right_out, a.right_out);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   pcm_scoreboard board = new();
   int      send_idle_pct = 30, recv_idle_pct = 49;
   bit      hold_off = 0;
   longint  cycle_count = 0;

   const logic [15:0] mapped_ports [] = '{16'h0B88, 16'h0B89, 16'h0B8A, 16'h0B8B,
      16'h0F8A, 16'h2789, 16'h7F89, 16'h8388, 16'h8389, 16'h838A, 16'h838B,
      16'h838C, 16'hEF8B, 16'hF388, 16'hF389, 16'hF38A, 16'hF38B, 16'hF38C,
      16'hF788, 16'hF789, 16'hFB8A, 16'hFF88, 16'hFF8B, 16'h0388, 16'h0F88};

   pcm_timer_dma_controller dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && !req_stall) board.note_request(req_data);
         if (rsp_valid && !rsp_stall) board.check_response(rsp_data);
      end
      if (cycle_count > 400000) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver stall pattern, plus a long hold-off on request
   always @(negedge clock) begin
      if (reset) rsp_stall <= 0;
      else if (hold_off) rsp_stall <= 1;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // valid stays up after acceptance until the next request or an idle cycle replaces it
   task automatic send_request(logic [1:0] kind, logic [15:0] port, logic [7:0] wd,
                               logic [7:0] b1, logic [7:0] b2);
      req_type r;
      r.kind = kind; r.port = port; r.write_data = wd; r.dma_first = b1; r.dma_second = b2;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic bus_write(logic [15:0] p, logic [7:0] v);
      send_request(KIND_WRITE, p, v, 8'($urandom), 8'($urandom));
   endtask

   task automatic bus_read(logic [15:0] p);
      send_request(KIND_READ, p, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic tick();
      send_request(KIND_TICK, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // well-formed timer setup with random content, then traffic
   task automatic random_burst();
      int ch, n;
      logic [7:0] v;
      ch = $urandom_range(2);
      if ($urandom_range(3) == 0) ch = 0;
      v = {ch[1:0], 2'($urandom_range(1, 3)), 3'($urandom), 1'b0};
      bus_write(16'(16'h1388 + ch), v);
      bus_write(16'h138B, v);
      bus_write(16'(16'h1388 + ch),
                ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(4)));
      bus_write(16'(16'h1388 + ch), ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom));
      n = $urandom_range(2, 12);
      repeat (n) begin
         case ($urandom_range(9))
            0, 1, 2, 3: tick();
            4: bus_read(16'(16'h1388 + $urandom_range(3)));
            5: bus_write(16'h138B, 8'($urandom));
            6: bus_read(mapped_ports[$urandom_range(mapped_ports.size() - 1)]);
            7: bus_write(mapped_ports[$urandom_range(mapped_ports.size() - 1)],
                         8'($urandom));
            8: send_request(2'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom));
            default: bus_write(16'h0B89, 8'($urandom));
         endcase
      end
   endtask

   task automatic run_phase(int bursts);
      repeat (bursts) random_burst();
   endtask

   initial begin
      board.clear_state();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: pcm on, stereo, enables, filter audible, small counts
      bus_write(16'h0B8B, 8'hFF);
      bus_write(16'h0B8A, 8'hFF);
      bus_write(16'h0F8A, PCM_ENA);
      bus_write(16'h138B, 8'h34);
      bus_write(16'h1388, 8'd1);
      bus_write(16'h1388, 8'd0);
      bus_write(16'h138B, 8'h50);          // channel 1 one-shot, low byte
      bus_write(16'h1389, 8'd3);
      send_request(KIND_TICK, 16'hFFFF, 8'hFF, 8'h00, 8'hFF);
      send_request(KIND_TICK, 16'h0000, 8'h00, 8'hFF, 8'h00);
      bus_write(16'h8389, SC2_16BIT | SC2_MSBINV);
      tick(); tick();
      bus_write(16'h138B, 8'h00);          // latch channel 0
      bus_read(16'h1388); bus_read(16'h1388);
      bus_write(16'h138B, 8'hCE);          // read-back all channels
      bus_write(16'h138B, 8'hEE);          // read-back with latch disabled
      bus_read(16'h1389); bus_read(16'h138B);
      bus_read(16'h0B89);
      bus_write(16'h0B89, 8'hFF);
      bus_write(16'h138B, 8'h9C);          // mode 6 folds to 2
      send_request(KIND_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
      bus_read(16'hFFFF);
      bus_write(16'h0000, 8'hAA);

      run_phase(65);
      send_idle_pct = 49; recv_idle_pct = 30;
      run_phase(25);
      // long receiver hold-off while requests keep coming
      fork
         begin
            @(negedge clock);
            hold_off = 1;
            repeat (60) @(negedge clock);
            hold_off = 0;
         end
         run_phase(8);
      join
      run_phase(25);
      send_idle_pct = 0; recv_idle_pct = 0;
      run_phase(40);
      req_valid <= 0;

      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.pending_rsp.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
